[hw/rtl/ppre_pkg.sv]
// ----------------------------------------------------------------------------
// ppre_pkg
// Shared constants for the pulse peak rate estimator.
// ----------------------------------------------------------------------------
package ppre_pkg;

  // Default depth of the peak history.
  localparam int PEAK_HISTORY_DEF = 16;

  // Field widths.
  localparam int SAMPLE_W = 24;
  localparam int POS_W    = 32;
  localparam int RATE_W   = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Saturation value of the since-peak counter.
  localparam logic [9:0] SINCE_PEAK_MAX = 10'd1000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 8'd3;

  // Register reset values.
  localparam logic [9:0]  SAMPLE_RATE_RST = 10'd25;
  localparam logic [9:0]  REFRACTORY_RST  = 10'd8;
  localparam logic [15:0] WINDOW_RST      = 16'd200;
  localparam logic [22:0] THRESHOLD_RST   = 23'd0;

endpackage

[hw/rtl/ppre_ram.sv]
// ----------------------------------------------------------------------------
// ppre_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pulse_peak_rate_estimator_core.sv]
// ----------------------------------------------------------------------------
// pulse_peak_rate_estimator_core
// Peak detector with a circular peak history in RAM and a heart rate output.
// ----------------------------------------------------------------------------
// Sequence: an accepted sample is taken in IDLE, then the stored peaks (at most
// PEAK_HISTORY) are read from RAM in a walk, the interval sum is checked, a
// restoring divide runs, and the result is loaded. An invalid rate skips the divide.
// A new sample is taken only after the result is loaded, and
// a stalled result holds the input off. Reset: synchronous, active low;
// registers take their defaults, no peaks.
module pulse_peak_rate_estimator_core
  import ppre_pkg::*;
#(
  parameter int PEAK_HISTORY = PEAK_HISTORY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_filtered_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_rate_valid,
  output logic [RATE_W-1:0]     out_rate_bpm_x16,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NW    = $clog2(PEAK_HISTORY);
  localparam int CW    = $clog2(PEAK_HISTORY + 1);
  localparam int SUM_W = POS_W + NW;
  localparam int CMP_W = SUM_W + 4;
  localparam int DIV_W = 24 + NW;
  localparam int DSH   = RATE_W - 1;
  localparam logic [NW-1:0] LAST_SLOT = NW'(PEAK_HISTORY - 1);

  typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_CHECK, ST_DIV, ST_DONE} state_t;

  // Configuration registers.
  logic [9:0]  fs_r, refr_r;
  logic [15:0] win_r;
  logic [22:0] thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r   <= SAMPLE_RATE_RST;
      refr_r <= REFRACTORY_RST;
      win_r  <= WINDOW_RST;
      thr_r  <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE: fs_r   <= cfg_wdata[9:0];
        REG_REFRACTORY:  refr_r <= cfg_wdata[9:0];
        REG_WINDOW:      win_r  <= cfg_wdata[15:0];
        REG_THRESHOLD:   thr_r  <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers.
  state_t               state_r;
  logic [SAMPLE_W-1:0]  last_r, before_r;
  logic [9:0]           since_r;
  logic [POS_W-1:0]     cnt_r, cutoff_r;
  logic [CW-1:0]        count_r, left_r;
  logic [NW-1:0]        head_r, ptr_r;
  logic                 rvld_r, have_prev_r;
  logic [POS_W-1:0]     prev_r;
  logic [SUM_W-1:0]     sum_r;
  logic [NW-1:0]        n_r;
  logic [DIV_W-1:0]     rem_r, dsh_r;
  logic [RATE_W-1:0]    q_r;
  logic [3:0]           step_r;
  logic                 res_valid_r;
  logic                 out_valid_r, out_rv_r;
  logic [RATE_W-1:0]    out_rate_r;

  // RAM signals.
  logic             ram_we;
  logic [NW-1:0]    ram_waddr;
  logic [POS_W-1:0] ram_rdata;

  // Peak test on the middle sample.
  logic [9:0]     since_inc;
  logic           is_peak;
  logic [CW:0]    slot_sum;
  logic [NW-1:0]  slot;
  logic [NW-1:0]  head_inc;
  logic [POS_W-1:0] cnt_inc;

  always_comb begin
    since_inc = (since_r < SINCE_PEAK_MAX) ? since_r + 10'd1 : since_r;
    is_peak = (|cnt_r[POS_W-1:1]) &&
              ($signed(last_r) > $signed(before_r)) &&
              ($signed(last_r) >= $signed(in_filtered_sample)) &&
              ($signed({last_r[SAMPLE_W-1], last_r}) > $signed({2'b00, thr_r})) &&
              (since_inc >= refr_r);
    slot_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    slot = (slot_sum >= (CW+1)'(PEAK_HISTORY)) ?
           NW'(slot_sum - (CW+1)'(PEAK_HISTORY)) : NW'(slot_sum);
    head_inc = (head_r == LAST_SLOT) ? '0 : head_r + NW'(1);
    cnt_inc = cnt_r + POS_W'(1);
    ram_we = (state_r == ST_IDLE) && in_valid && is_peak;
    ram_waddr = (count_r < CW'(PEAK_HISTORY)) ? slot : head_r;
  end

  ppre_ram #(.WIDTH(POS_W), .DEPTH(PEAK_HISTORY)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cnt_r),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Interval accumulation from the read data.
  logic [POS_W-1:0] diff;
  logic             take;
  assign diff = ram_rdata - prev_r;
  assign take = rvld_r && (ram_rdata >= cutoff_r);

  // Range check: 2*fs*n >= S and 3*fs*n <= 11*S.
  logic [10+NW-1:0] fsn;
  logic [CMP_W-1:0] fsn_w, sum_w;
  logic             rate_ok;
  logic [DIV_W-1:0] num, dvs;
  always_comb begin
    fsn = (10+NW)'(fs_r) * (10+NW)'(n_r);
    fsn_w = CMP_W'(fsn);
    sum_w = CMP_W'(sum_r);
    rate_ok = (n_r != '0) && ((fsn_w << 1) >= sum_w) &&
              ((fsn_w << 1) + fsn_w <= (sum_w << 3) + (sum_w << 1) + sum_w);
    num = (DIV_W'(fsn) << 11) - (DIV_W'(fsn) << 7) + DIV_W'(sum_r[DIV_W-2:0]);
    dvs = DIV_W'(sum_r[DIV_W-2:0]) << 1;
  end

  // Sequencer: update, walk the history, check, divide, deliver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      before_r    <= '0;
      since_r     <= SINCE_PEAK_MAX;
      cnt_r       <= '0;
      count_r     <= '0;
      head_r      <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            before_r <= last_r;
            last_r   <= in_filtered_sample;
            cnt_r    <= cnt_inc;
            cutoff_r <= (cnt_inc > POS_W'(win_r)) ? cnt_inc - POS_W'(win_r) : '0;
            have_prev_r <= 1'b0;
            sum_r <= '0;
            n_r   <= '0;
            rvld_r <= 1'b0;
            if (is_peak) begin
              since_r <= '0;
              if (count_r < CW'(PEAK_HISTORY)) begin
                count_r <= count_r + CW'(1);
                left_r  <= count_r + CW'(1);
                ptr_r   <= head_r;
              end else begin
                head_r <= head_inc;
                left_r <= count_r;
                ptr_r  <= head_inc;
              end
            end else begin
              since_r <= since_inc;
              left_r  <= count_r;
              ptr_r   <= head_r;
            end
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (left_r != '0) begin
            left_r <= left_r - CW'(1);
            ptr_r  <= (ptr_r == LAST_SLOT) ? '0 : ptr_r + NW'(1);
            rvld_r <= 1'b1;
          end else begin
            rvld_r <= 1'b0;
          end
          if (take) begin
            if (have_prev_r && diff != '0) begin
              sum_r <= sum_r + SUM_W'(diff);
              n_r   <= n_r + NW'(1);
            end
            prev_r      <= ram_rdata;
            have_prev_r <= 1'b1;
          end
          if (left_r == '0 && !rvld_r) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res_valid_r <= rate_ok;
          rem_r  <= num;
          dsh_r  <= dvs << DSH;
          q_r    <= '0;
          step_r <= '0;
          state_r <= rate_ok ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            q_r   <= {q_r[RATE_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[RATE_W-2:0], 1'b0};
          end
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r + 4'd1;
          if (step_r == 4'(RATE_W - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_rv_r    <= res_valid_r;
            out_rate_r  <= res_valid_r ? q_r : '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_rate_valid   = out_rv_r;
  assign out_rate_bpm_x16 = out_rate_r;

`ifndef SYNTHESIS
  // An accepted request always starts a busy period.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a request");

  // The history never holds more peaks than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(PEAK_HISTORY))
    else $error("peak count beyond history depth");

  // An invalid rate always reads as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rate_valid |-> out_rate_bpm_x16 == '0)
    else $error("nonzero rate on an invalid result");

  // A RAM write happens only on the update cycle of a request.
  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> in_valid && !in_stall)
    else $error("history written outside a request");
`endif

endmodule
